FILE: rtl/core/h2r_pkg.sv
// ---------------------------------------------------------------------------
// h2r_pkg
// Shared types, constants and helpers of the integer HSV to RGB converter.
// ---------------------------------------------------------------------------
package h2r_pkg;

	localparam int HUE_W  = 16;
	localparam int CH_W   = 8;
	localparam int STAGES = 7;

	// hue / 360 estimate: floor(hue * HUE_RECIP / 2^24), low by at most one
	localparam logic [15:0] HUE_RECIP = 16'd46603;
	localparam logic [8:0]  DEG_FULL  = 9'd360;
	localparam logic [8:0]  DEG_SEXT  = 9'd60;
	// sextant = (hue mod 360) * SEXT_RECIP >> 16, exact below 360
	localparam logic [10:0] SEXT_RECIP = 11'd1093;
	// fraction = remainder * 255 / 60 = remainder * 17 / 4
	localparam logic [9:0]  FRAC_MUL   = 10'd17;

	// sextant codes, named by the hue span they cover
	localparam logic [2:0] SEXT_RY = 3'd0;
	localparam logic [2:0] SEXT_YG = 3'd1;
	localparam logic [2:0] SEXT_GC = 3'd2;
	localparam logic [2:0] SEXT_CB = 3'd3;
	localparam logic [2:0] SEXT_BM = 3'd4;
	localparam logic [2:0] SEXT_MR = 3'd5;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} h2r_adv_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// exact floor(prod / 255) for any product of two 8-bit values
	function automatic logic [7:0] div255(input logic [15:0] prod);
		logic [16:0] sum;
		sum = 17'(prod) + 17'(prod[15:8]) + 17'd1;
		return sum[15:8];
	endfunction

endpackage

FILE: rtl/core/h2r_hsv_if.sv
// ---------------------------------------------------------------------------
// h2r_hsv_if
// Valid/ready channel carrying one HSV colour per beat.
// ---------------------------------------------------------------------------
interface h2r_hsv_if import h2r_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [HUE_W-1:0] hue;
	logic [CH_W-1:0]  saturation;
	logic [CH_W-1:0]  value;

	modport source (output valid, output hue, output saturation, output value, input ready);
	modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

FILE: rtl/core/h2r_rgb_if.sv
// ---------------------------------------------------------------------------
// h2r_rgb_if
// Valid/ready channel carrying one RGB colour per beat.
// ---------------------------------------------------------------------------
interface h2r_rgb_if import h2r_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: rtl/core/h2r_hue_reduce.sv
// ---------------------------------------------------------------------------
// h2r_hue_reduce
// Stages 1-2: hue modulo 360 by reciprocal multiply and one correction,
// plus the raw product for p.
// ---------------------------------------------------------------------------
module h2r_hue_reduce import h2r_pkg::*; (
	input  logic             clk,
	input  h2r_adv_t         adv,
	input  logic [HUE_W-1:0] hue,
	input  logic [CH_W-1:0]  sat,
	input  logic [CH_W-1:0]  val,
	output logic [8:0]       hm_s2,
	output logic [CH_W-1:0]  sat_s2,
	output logic [CH_W-1:0]  val_s2,
	output logic [15:0]      pprod_s2
);

	logic [31:0]      hue_prod;
	logic [7:0]       quo_s1;
	logic [HUE_W-1:0] hue_s1;
	logic [CH_W-1:0]  sat_s1;
	logic [CH_W-1:0]  val_s1;
	logic [16:0]      quo_x360;
	logic [16:0]      rem;
	logic [16:0]      rem_fix;

	assign hue_prod = {16'd0, hue} * {16'd0, HUE_RECIP};

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			quo_s1 <= hue_prod[31:24];
			hue_s1 <= hue;
			sat_s1 <= sat;
			val_s1 <= val;
		end
	end

	// estimate may be one low, so the remainder is below 720
	assign quo_x360 = 17'(quo_s1) * 17'(DEG_FULL);
	assign rem      = {1'b0, hue_s1} - quo_x360;
	assign rem_fix  = (rem >= 17'(DEG_FULL)) ? rem - 17'(DEG_FULL) : rem;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			hm_s2    <= rem_fix[8:0];
			sat_s2   <= sat_s1;
			val_s2   <= val_s1;
			pprod_s2 <= 16'(val_s1) * {8'd0, ~sat_s1};
		end
	end

endmodule

FILE: rtl/core/h2r_sector.sv
// ---------------------------------------------------------------------------
// h2r_sector
// Stages 3-4: sextant and fraction of the reduced hue, and p.
// ---------------------------------------------------------------------------
module h2r_sector import h2r_pkg::*; (
	input  logic            clk,
	input  h2r_adv_t        adv,
	input  logic [8:0]      hm,
	input  logic [CH_W-1:0] sat,
	input  logic [CH_W-1:0] val,
	input  logic [15:0]     pprod,
	output logic [7:0]      frac_s4,
	output logic [2:0]      sext_s4,
	output logic [CH_W-1:0] p_s4,
	output logic [CH_W-1:0] sat_s4,
	output logic [CH_W-1:0] val_s4
);

	logic [19:0]     sext_prod;
	logic [8:0]      hm_s3;
	logic [2:0]      sext_s3;
	logic [CH_W-1:0] p_s3;
	logic [CH_W-1:0] sat_s3;
	logic [CH_W-1:0] val_s3;
	logic [8:0]      rem60;
	logic [9:0]      frac_x4;

	assign sext_prod = 20'(hm) * 20'(SEXT_RECIP);

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			hm_s3   <= hm;
			sext_s3 <= sext_prod[18:16];
			p_s3    <= div255(pprod);
			sat_s3  <= sat;
			val_s3  <= val;
		end
	end

	assign rem60   = hm_s3 - 9'(sext_s3) * DEG_SEXT;
	assign frac_x4 = 10'(rem60[5:0]) * FRAC_MUL;

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			frac_s4 <= frac_x4[9:2];
			sext_s4 <= sext_s3;
			p_s4    <= p_s3;
			sat_s4  <= sat_s3;
			val_s4  <= val_s3;
		end
	end

endmodule

FILE: rtl/core/h2r_blend.sv
// ---------------------------------------------------------------------------
// h2r_blend
// Stages 5-7: q and t by two nested scalings, then the sextant ordering.
// ---------------------------------------------------------------------------
module h2r_blend import h2r_pkg::*; (
	input  logic            clk,
	input  h2r_adv_t        adv,
	input  logic [7:0]      frac,
	input  logic [2:0]      sext,
	input  logic [CH_W-1:0] p,
	input  logic [CH_W-1:0] sat,
	input  logic [CH_W-1:0] val,
	output rgb_t            rgb_s7
);

	logic [15:0]     qm_s5;
	logic [15:0]     tm_s5;
	logic [2:0]      sext_s5;
	logic [CH_W-1:0] p_s5;
	logic [CH_W-1:0] val_s5;
	logic [7:0]      qs;
	logic [7:0]      ts;
	logic [15:0]     qp_s6;
	logic [15:0]     tp_s6;
	logic [2:0]      sext_s6;
	logic [CH_W-1:0] p_s6;
	logic [CH_W-1:0] val_s6;
	logic [7:0]      q;
	logic [7:0]      t;
	rgb_t            rgb_nxt;

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			qm_s5   <= 16'(frac) * 16'(sat);
			tm_s5   <= {8'd0, ~frac} * 16'(sat);
			sext_s5 <= sext;
			p_s5    <= p;
			val_s5  <= val;
		end
	end

	assign qs = div255(qm_s5);
	assign ts = div255(tm_s5);

	always_ff @(posedge clk) begin
		if (adv.s6) begin
			qp_s6   <= 16'(val_s5) * {8'd0, ~qs};
			tp_s6   <= 16'(val_s5) * {8'd0, ~ts};
			sext_s6 <= sext_s5;
			p_s6    <= p_s5;
			val_s6  <= val_s5;
		end
	end

	assign q = div255(qp_s6);
	assign t = div255(tp_s6);

	always_comb begin
		case (sext_s6)
			SEXT_RY: rgb_nxt = '{red: val_s6, green: t,      blue: p_s6};
			SEXT_YG: rgb_nxt = '{red: q,      green: val_s6, blue: p_s6};
			SEXT_GC: rgb_nxt = '{red: p_s6,   green: val_s6, blue: t};
			SEXT_CB: rgb_nxt = '{red: p_s6,   green: q,      blue: val_s6};
			SEXT_BM: rgb_nxt = '{red: t,      green: p_s6,   blue: val_s6};
			SEXT_MR: rgb_nxt = '{red: val_s6, green: p_s6,   blue: q};
			default: rgb_nxt = '{red: val_s6, green: p_s6,   blue: q};
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s7) begin
			rgb_s7 <= rgb_nxt;
		end
	end

endmodule

FILE: rtl/core/hsv_to_rgb_integer.sv
// ---------------------------------------------------------------------------
// hsv_to_rgb_integer
// Integer HSV to 8-bit RGB converter, seven-stage valid/ready pipeline.
// ---------------------------------------------------------------------------
// Takes one HSV beat per clock while the output side keeps ready high and
// returns one RGB beat for each, in order. The hue is reduced modulo 360,
// split into a sextant and a fraction from 0 to 250, and p, q, t are built
// with exact truncating x*y/255 scalings; the sextant then routes value, p,
// q and t onto red, green and blue. The work is spread over seven register
// stages, with the hue reciprocal multiply first and the two nested q/t
// scalings later. Sustained rate is one beat per cycle while the output side
// keeps ready high. Every stage has its own valid bit and advances whenever
// it is empty or the stage after it moves, so a stalled output only holds
// the stages that are full and bubbles in the pipe are squeezed out while
// the last result waits to be taken. There is no state beyond the pipeline
// and nothing to configure.
// ---------------------------------------------------------------------------
module hsv_to_rgb_integer import h2r_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	h2r_hsv_if.sink     hsv,
	h2r_rgb_if.source   rgb
);

	// per-stage valid bits and the ready chain running back from the output
	logic [STAGES:1]   stage_vld_q;
	logic [STAGES:1]   vld_in;
	logic [STAGES+1:1] rdy;
	h2r_adv_t          adv;

	// stage 2 outputs
	logic [8:0]      hm_s2;
	logic [CH_W-1:0] sat_s2;
	logic [CH_W-1:0] val_s2;
	logic [15:0]     pprod_s2;

	// stage 4 outputs
	logic [7:0]      frac_s4;
	logic [2:0]      sext_s4;
	logic [CH_W-1:0] p_s4;
	logic [CH_W-1:0] sat_s4;
	logic [CH_W-1:0] val_s4;

	// output register
	rgb_t            rgb_s7;

	// a stage may load when it is empty or its contents move on
	always_comb begin
		rdy[STAGES+1] = rgb.ready;
		for (int k = STAGES; k >= 1; k--) begin
			rdy[k] = !stage_vld_q[k] || rdy[k+1];
		end
	end

	assign adv = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4],
	               s5: rdy[5], s6: rdy[6], s7: rdy[7]};

	assign vld_in = {stage_vld_q[STAGES-1:1], hsv.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			for (int k = 1; k <= STAGES; k++) begin
				if (rdy[k]) begin
					stage_vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	assign hsv.ready = rdy[1];

	// stages 1-2: hue mod 360, raw p product
	h2r_hue_reduce u_hue_reduce (
		.clk      (clk),
		.adv      (adv),
		.hue      (hsv.hue),
		.sat      (hsv.saturation),
		.val      (hsv.value),
		.hm_s2    (hm_s2),
		.sat_s2   (sat_s2),
		.val_s2   (val_s2),
		.pprod_s2 (pprod_s2)
	);

	// stages 3-4: sextant, fraction, p
	h2r_sector u_sector (
		.clk     (clk),
		.adv     (adv),
		.hm      (hm_s2),
		.sat     (sat_s2),
		.val     (val_s2),
		.pprod   (pprod_s2),
		.frac_s4 (frac_s4),
		.sext_s4 (sext_s4),
		.p_s4    (p_s4),
		.sat_s4  (sat_s4),
		.val_s4  (val_s4)
	);

	// stages 5-7: q, t and channel ordering into the output register
	h2r_blend u_blend (
		.clk    (clk),
		.adv    (adv),
		.frac   (frac_s4),
		.sext   (sext_s4),
		.p      (p_s4),
		.sat    (sat_s4),
		.val    (val_s4),
		.rgb_s7 (rgb_s7)
	);

	assign rgb.valid = stage_vld_q[STAGES];
	assign rgb.red   = rgb_s7.red;
	assign rgb.green = rgb_s7.green;
	assign rgb.blue  = rgb_s7.blue;

endmodule

FILE: rtl/core/h2r_checker.sv
// ---------------------------------------------------------------------------
// h2r_checker
// Port-level checks for the HSV to RGB converter, bound to the top level.
// ---------------------------------------------------------------------------
module h2r_checker import h2r_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_ready,
	input  logic            out_valid,
	input  logic            out_ready,
	input  logic [CH_W-1:0] out_red,
	input  logic [CH_W-1:0] out_green,
	input  logic [CH_W-1:0] out_blue
);

	// a stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its colour
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_red) && $stable(out_green)
			&& $stable(out_blue))
		else $error("result beat changed while stalled");

	// reset empties the pipe, so no result is offered just after reset is seen
	a_rst_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result offered during reset");

	// with the output side taking beats, the whole pipe moves
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output ready");

	// input is held back only by a full pipe behind a waiting result
	a_in_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind hsv_to_rgb_integer h2r_checker u_h2r_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (hsv.valid),
	.in_ready  (hsv.ready),
	.out_valid (rgb.valid),
	.out_ready (rgb.ready),
	.out_red   (rgb.red),
	.out_green (rgb.green),
	.out_blue  (rgb.blue)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Checks the integer HSV to RGB converter against a bit-exact predictor.
// ---------------------------------------------------------------------------
// A driver pushes HSV beats from a queue that the stimulus block fills first.
// The queue holds a directed set (wrap of the hue, every sextant, zero
// saturation and value, the fraction ceiling) and then 1560 random
// beats. Each accepted beat is turned into its expected RGB colour at the
// input. The output side takes results in order and compares every channel
// with the oldest expected colour. Both sides idle at random.
// ---------------------------------------------------------------------------
module tb_top;
	import h2r_pkg::*;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_MIXED, IDLE_HEAVY} idle_mode_t;

	typedef struct {
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  saturation;
		logic [CH_W-1:0]  value;
		int unsigned      gap;    // idle cycles before the beat is offered
		bit               drain;  // hold the beat until no colour is outstanding
	} hsv_beat_t;

	localparam int unsigned RANDOM_BLOCKS = 13;
	localparam int unsigned BLOCK_BEATS   = 120;
	localparam int unsigned TAIL_CYCLES   = 20;  // more than the 7 stages
	localparam int unsigned PRINT_CAP     = 50;

	logic clk;
	logic arst_n;

	h2r_hsv_if hsv_ch();
	h2r_rgb_if rgb_ch();

	hsv_beat_t   hsv_pending[$];   // beats not yet offered to the converter
	rgb_t        rgb_expected[$];  // colours owed by the converter, oldest first
	int unsigned mismatch_count;
	int unsigned gap_count;
	int unsigned stall_left;
	int unsigned sink_beats;
	idle_mode_t  sink_mode;

	hsv_to_rgb_integer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv_ch),
		.rgb    (rgb_ch)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// truncating x*y/255
	function automatic logic [7:0] scale255(input logic [7:0] x, input logic [7:0] y);
		logic [15:0] prod;
		prod = 16'(x) * 16'(y);
		return 8'(prod / 16'd255);
	endfunction

	// expected colour for one HSV beat
	function automatic rgb_t rgb_from_hsv(input logic [15:0] hue, input logic [7:0] sat,
			input logic [7:0] val);
		logic [8:0] deg;
		logic [5:0] rem;
		logic [2:0] sext;
		logic [7:0] frac;
		logic [7:0] p;
		logic [7:0] q;
		logic [7:0] t;
		rgb_t       rgb;
		deg  = 9'(hue % 16'd360);
		sext = 3'(deg / 9'd60);
		rem  = 6'(deg % 9'd60);
		// fraction tops out at 250, never 255
		frac = 8'((16'(rem) * 16'd255) / 16'd60);
		p    = scale255(val, 8'd255 - sat);
		q    = scale255(val, 8'd255 - scale255(frac, sat));
		t    = scale255(val, 8'd255 - scale255(8'd255 - frac, sat));
		case (sext)
			SEXT_RY: rgb = '{red: val, green: t,   blue: p};
			SEXT_YG: rgb = '{red: q,   green: val, blue: p};
			SEXT_GC: rgb = '{red: p,   green: val, blue: t};
			SEXT_CB: rgb = '{red: p,   green: q,   blue: val};
			SEXT_BM: rgb = '{red: t,   green: p,   blue: val};
			default: rgb = '{red: val, green: p,   blue: q};
		endcase
		return rgb;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_idle(input idle_mode_t mode);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (mode == IDLE_NONE)
			return 0;
		if (mode == IDLE_HEAVY)
			r = r / 2 + 50;
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// channel value, biased toward the ends of the range
	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(1, 2));
			3: return 8'($urandom_range(253, 254));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void add_beat(input logic [15:0] hue, input logic [7:0] sat,
			input logic [7:0] val, input int unsigned gap, input bit drain);
		hsv_beat_t beat;
		beat.hue        = hue;
		beat.saturation = sat;
		beat.value      = val;
		beat.gap        = gap;
		beat.drain      = drain;
		hsv_pending.push_back(beat);
	endfunction

	task automatic report_mismatch(input string what, input rgb_t got, input rgb_t want);
		if (mismatch_count < PRINT_CAP)
			$display("%0t ns: rgb mismatch (%s): got %02h_%02h_%02h, expected %02h_%02h_%02h",
				$time, what, got.red, got.green, got.blue, want.red, want.green, want.blue);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// driver: offers queued HSV beats, predicts each one as it is taken
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : hsv_feed
		hsv_beat_t beat;
		if (!arst_n) begin
			hsv_ch.valid      <= 1'b0;
			hsv_ch.hue        <= '0;
			hsv_ch.saturation <= '0;
			hsv_ch.value      <= '0;
			gap_count         <= 0;
		end else begin
			// beat taken at this edge: its colour is now owed
			if (hsv_ch.valid && hsv_ch.ready)
				rgb_expected.push_back(rgb_from_hsv(hsv_ch.hue, hsv_ch.saturation,
					hsv_ch.value));
			// channel is free for the next beat
			if (!hsv_ch.valid || hsv_ch.ready) begin
				if (hsv_pending.size() != 0 && gap_count >= hsv_pending[0].gap
						&& (!hsv_pending[0].drain || rgb_expected.size() == 0)) begin
					beat = hsv_pending.pop_front();
					hsv_ch.valid      <= 1'b1;
					hsv_ch.hue        <= beat.hue;
					hsv_ch.saturation <= beat.saturation;
					hsv_ch.value      <= beat.value;
					gap_count         <= 0;
				end else begin
					// idle cycle: payload is junk and must be ignored
					hsv_ch.valid      <= 1'b0;
					hsv_ch.hue        <= 16'($urandom);
					hsv_ch.saturation <= 8'($urandom);
					hsv_ch.value      <= 8'($urandom);
					if (hsv_pending.size() != 0 && gap_count < hsv_pending[0].gap)
						gap_count <= gap_count + 1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: takes RGB beats with random stalls, checks each channel
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : rgb_check
		rgb_t  got;
		rgb_t  want;
		string bad;
		if (!arst_n) begin
			rgb_ch.ready <= 1'b0;
			stall_left   <= 0;
			sink_beats   <= 0;
			sink_mode    <= IDLE_NONE;
		end else begin
			if (rgb_ch.valid && rgb_ch.ready) begin
				got = '{red: rgb_ch.red, green: rgb_ch.green, blue: rgb_ch.blue};
				if (rgb_expected.size() == 0) begin
					report_mismatch("no colour outstanding", got, '0);
				end else begin
					want = rgb_expected.pop_front();
					bad  = "";
					if (got.red !== want.red)
						bad = {bad, " red"};
					if (got.green !== want.green)
						bad = {bad, " green"};
					if (got.blue !== want.blue)
						bad = {bad, " blue"};
					if (bad != "")
						report_mismatch({"wrong", bad}, got, want);
				end
				// change the stall pattern every so many results
				sink_beats <= sink_beats + 1;
				if (sink_beats % BLOCK_BEATS == BLOCK_BEATS - 1)
					sink_mode <= idle_mode_t'($urandom_range(0, 2));
			end
			if (stall_left != 0) begin
				rgb_ch.ready <= 1'b0;
				stall_left   <= stall_left - 1;
			end else begin
				rgb_ch.ready <= 1'b1;
				stall_left   <= pick_idle(sink_mode);
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin : stimulus
		idle_mode_t  mode;
		logic [15:0] hue;
		hsv_ch.valid      = 1'b0;
		hsv_ch.hue        = '0;
		hsv_ch.saturation = '0;
		hsv_ch.value      = '0;
		rgb_ch.ready      = 1'b0;
		arst_n            = 1'b0;
		mismatch_count    = 0;

		// directed: one hue per sextant start, full colour
		add_beat(16'd0,     8'd255, 8'd255, 0, 1'b0);
		add_beat(16'd60,    8'd255, 8'd255, 0, 1'b0);
		add_beat(16'd120,   8'd255, 8'd255, 0, 1'b0);
		add_beat(16'd180,   8'd255, 8'd255, 0, 1'b0);
		add_beat(16'd240,   8'd255, 8'd255, 0, 1'b0);
		add_beat(16'd300,   8'd255, 8'd255, 0, 1'b0);
		// end of the circle and hue wrap, 360 acts as 0
		add_beat(16'd359,   8'd255, 8'd255, 0, 1'b0);
		add_beat(16'd360,   8'd255, 8'd255, 0, 1'b0);
		add_beat(16'd65535, 8'd255, 8'd255, 2, 1'b0);
		add_beat(16'd65520, 8'd128, 8'd128, 0, 1'b0);
		add_beat(16'd719,   8'd255, 8'd128, 0, 1'b0);
		// fraction ceiling at the last degree of a sextant
		add_beat(16'd59,    8'd255, 8'd255, 0, 1'b0);
		add_beat(16'd119,   8'd200, 8'd180, 0, 1'b0);
		add_beat(16'd239,   8'd1,   8'd255, 3, 1'b0);
		add_beat(16'd299,   8'd254, 8'd1,   0, 1'b0);
		// zero saturation gives grey at the value
		add_beat(16'd30,    8'd0,   8'd200, 0, 1'b0);
		add_beat(16'd200,   8'd0,   8'd255, 0, 1'b0);
		// zero value gives black
		add_beat(16'd100,   8'd255, 8'd0,   0, 1'b0);
		add_beat(16'd300,   8'd128, 8'd0,   0, 1'b0);
		add_beat(16'd0,     8'd0,   8'd0,   1, 1'b0);
		// mid-sextant, arbitrary mixes
		add_beat(16'd45,    8'd128, 8'd255, 0, 1'b0);
		add_beat(16'd165,   8'd77,  8'd33,  0, 1'b0);
		add_beat(16'd270,   8'd170, 8'd85,  0, 1'b0);
		add_beat(16'd333,   8'd255, 8'd254, 0, 1'b0);

		// random blocks, each with its own idle pattern; some start on an empty pipe
		for (int unsigned blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			mode = (blk == 0) ? IDLE_NONE : idle_mode_t'($urandom_range(0, 2));
			for (int unsigned i = 0; i < BLOCK_BEATS; i++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: hue = 16'($urandom);
					6, 7, 8: hue = 16'($urandom_range(0, 359));
					// either side of a sextant boundary, possibly past one turn
					default: hue = 16'($urandom_range(0, 5) * 60
						+ ($urandom_range(0, 1) ? 59 : 0) + $urandom_range(0, 180) * 360);
				endcase
				add_beat(hue, pick_channel(), pick_channel(), pick_idle(mode),
					i == 0 && blk % 4 == 3);
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// all beats taken and every colour back
		while (hsv_pending.size() != 0 || hsv_ch.valid || rgb_expected.size() != 0)
			@(posedge clk);
		// nothing further may come out
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && rgb_expected.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#4000000;
		$display("timeout: %0d colours still outstanding", rgb_expected.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
